// File: rtl/bts_pkg.sv
`default_nettype none

package bts_pkg;

    localparam int MAX_TRIALS_DEFAULT = 64;
    localparam int QUEUE_DEPTH        = 2;

    localparam int TRIALS_W = 10;
    localparam int INDEX_W  = 6;
    localparam int FRAC_W   = 32;
    localparam int ROWS_W   = 7;
    localparam int SUCC_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [SUCC_W-1:0] SUCC_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P_FRACTION  = 2'd0,
        REG_ROWS_LOADED = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SINGLE = 2'd1,
        CMD_BAD    = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_STEP,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/bts_queue.sv
`default_nettype none

module bts_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bts_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bts_front.sv
`default_nettype none

module bts_front #(
    parameter int MAX_TRIALS = bts_pkg::MAX_TRIALS_DEFAULT,
    localparam int DEPTH = MAX_TRIALS * (MAX_TRIALS + 1) / 2,
    localparam int AW    = $clog2(DEPTH),
    localparam int NW    = $clog2(MAX_TRIALS + 1),
    localparam int EW    = bts_pkg::FRAC_W + AW + NW + 2
) (
    input  wire logic                        is_sample,
    input  wire logic [bts_pkg::TRIALS_W-1:0] trials,
    input  wire logic [bts_pkg::INDEX_W-1:0]  entry_index,
    input  wire logic [bts_pkg::FRAC_W-1:0]   cdf_value,
    input  wire logic [bts_pkg::FRAC_W-1:0]   uniform,
    input  wire logic [bts_pkg::ROWS_W-1:0]   rows_loaded,
    output logic                             push,
    output logic      [EW-1:0]               entry
);

    localparam int PW = 2 * NW;

    logic [NW-1:0]              n_short;
    logic [PW-1:0]              prod;
    logic [AW-1:0]              base;
    logic                       n_in_store;
    logic                       load_ok;
    bts_pkg::cmd_t              kind;
    logic [AW-1:0]              addr;
    logic [bts_pkg::FRAC_W-1:0] value;

    // row n starts at word (n-1)*n/2
    assign n_short    = NW'(trials);
    assign prod       = PW'(n_short - 1'b1) * PW'(n_short);
    assign base       = AW'(prod >> 1);
    assign n_in_store = (trials != '0) &&
                        (trials <= bts_pkg::TRIALS_W'(MAX_TRIALS));
    assign load_ok    = n_in_store && (bts_pkg::TRIALS_W'(entry_index) < trials);

    always_comb begin
        kind  = bts_pkg::CMD_LOAD;
        addr  = base + AW'(entry_index);
        value = cdf_value;
        push  = load_ok;
        if (is_sample) begin
            push  = 1'b1;
            addr  = base;
            value = uniform;
            if (trials == bts_pkg::TRIALS_W'(1)) begin
                kind = bts_pkg::CMD_SINGLE;
            end else if (!n_in_store ||
                         (trials > bts_pkg::TRIALS_W'(rows_loaded))) begin
                kind = bts_pkg::CMD_BAD;
            end else begin
                kind = bts_pkg::CMD_SEARCH;
            end
        end
    end

    assign entry = {value, addr, n_short, kind};

endmodule

`default_nettype wire

// File: rtl/bts_back.sv
`default_nettype none

module bts_back #(
    parameter int MAX_TRIALS = bts_pkg::MAX_TRIALS_DEFAULT,
    localparam int DEPTH = MAX_TRIALS * (MAX_TRIALS + 1) / 2,
    localparam int AW    = $clog2(DEPTH),
    localparam int NW    = $clog2(MAX_TRIALS + 1),
    localparam int EW    = bts_pkg::FRAC_W + AW + NW + 2
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    output logic                             q_ready,
    input  wire logic [EW-1:0]               q_entry,
    input  wire logic [bts_pkg::FRAC_W-1:0]  p_fraction,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [bts_pkg::SUCC_W-1:0]  m_successes,
    output logic                             m_out_of_range
);

    bts_pkg::cmd_t              q_kind;
    logic [NW-1:0]              q_n;
    logic [AW-1:0]              q_addr;
    logic [bts_pkg::FRAC_W-1:0] q_value;

    assign {q_value, q_addr, q_n, q_kind} = q_entry;

    logic [bts_pkg::FRAC_W-1:0] mem [DEPTH];
    logic [bts_pkg::FRAC_W-1:0] rd_data_reg;

    bts_pkg::back_state_t state_reg, state_next;

    logic [NW-1:0]              lo_reg, hi_reg, mid_reg;
    logic [AW-1:0]              base_reg;
    logic [bts_pkg::FRAC_W-1:0] u_reg;

    logic                       m_valid_reg;
    logic [bts_pkg::SUCC_W-1:0] succ_reg;
    logic                       oor_reg;

    logic                       out_free;
    logic                       cmp_gt;
    logic [NW-1:0]              step_lo, step_hi, step_mid;
    logic                       step_more;

    logic                       wr_en, rd_en, res_load, start;
    logic [AW-1:0]              rd_addr;
    logic [bts_pkg::SUCC_W-1:0] res_succ;
    logic                       res_oor;
    logic [bts_pkg::SUCC_W-1:0] lo_sat;

    assign out_free = !m_valid_reg || m_ready;

    // one halving of the search window per cycle
    assign cmp_gt    = rd_data_reg > u_reg;
    assign step_lo   = cmp_gt ? lo_reg : mid_reg + 1'b1;
    assign step_hi   = cmp_gt ? mid_reg : hi_reg;
    assign step_mid  = step_lo + ((step_hi - step_lo) >> 1);
    assign step_more = step_lo < step_hi;

    assign lo_sat = (32'(lo_reg) > 32'(bts_pkg::SUCC_MAX)) ? bts_pkg::SUCC_MAX
                                                           : bts_pkg::SUCC_W'(lo_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bts_pkg::BK_IDLE: begin
                if (q_valid && (q_kind == bts_pkg::CMD_SEARCH)) begin
                    state_next = bts_pkg::BK_STEP;
                end
            end
            bts_pkg::BK_STEP: begin
                if (!step_more) begin
                    state_next = bts_pkg::BK_DONE;
                end
            end
            bts_pkg::BK_DONE: begin
                if (out_free) begin
                    state_next = bts_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = bts_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        q_ready  = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        start    = 1'b0;
        rd_addr  = q_addr + AW'(q_n >> 1);
        res_load = 1'b0;
        res_succ = '0;
        res_oor  = 1'b0;
        case (state_reg)
            bts_pkg::BK_IDLE: begin
                case (q_kind)
                    bts_pkg::CMD_LOAD: begin
                        q_ready = q_valid;
                        wr_en   = q_valid;
                    end
                    bts_pkg::CMD_SINGLE: begin
                        q_ready  = q_valid && out_free;
                        res_load = q_valid && out_free;
                        res_succ = (q_value > p_fraction) ? '0 : bts_pkg::SUCC_W'(1);
                    end
                    bts_pkg::CMD_BAD: begin
                        q_ready  = q_valid && out_free;
                        res_load = q_valid && out_free;
                        res_oor  = 1'b1;
                    end
                    bts_pkg::CMD_SEARCH: begin
                        q_ready = q_valid;
                        rd_en   = q_valid;
                        start   = q_valid;
                    end
                    default: begin
                        q_ready = q_valid;
                    end
                endcase
            end
            bts_pkg::BK_STEP: begin
                rd_en   = step_more;
                rd_addr = base_reg + AW'(step_mid);
            end
            bts_pkg::BK_DONE: begin
                res_load = out_free;
                res_succ = lo_sat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bts_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            lo_reg   <= '0;
            hi_reg   <= q_n;
            mid_reg  <= q_n >> 1;
            base_reg <= q_addr;
            u_reg    <= q_value;
        end else if (state_reg == bts_pkg::BK_STEP) begin
            lo_reg  <= step_lo;
            hi_reg  <= step_hi;
            mid_reg <= step_mid;
        end
        if (res_load) begin
            succ_reg <= res_succ;
            oor_reg  <= res_oor;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[q_addr] <= q_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_successes    = succ_reg;
    assign m_out_of_range = oor_reg;

endmodule

`default_nettype wire

// File: rtl/binomial_table_sampler.sv
// Binomial sampler by inverse-transform lookup. A load word (tuser 0) writes one cumulative
// fraction into the triangular table (row n holds n entries) and returns nothing; loads with
// n = 0, n > MAX_TRIALS or k >= n are dropped. A sample word (tuser 1) returns one word: for
// n = 1 the result compares uniform with p_fraction; for 2 <= n <= rows_loaded, n <= MAX_TRIALS,
// a binary search of row n returns the first index whose entry exceeds uniform, or n; otherwise
// the result is 0 with out_of_range set. The front classifies each word and computes its table
// address, a two-entry queue decouples it from the back, which owns the single-port table RAM.
// Loads, single-trial and unserved samples are finished in the back's idle state; a search
// steps through the table with one registered RAM read per step. Table entries read before
// being loaded give undefined results. The user must write configuration only while the block
// is idle; the block itself does not enforce it.
`default_nettype none

module binomial_table_sampler #(
    parameter int MAX_TRIALS = bts_pkg::MAX_TRIALS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [79:0]                    s_axis_tdata,  // trials, entry_index, cdf_value, uniform
    input  wire logic [0:0]                     s_axis_tuser,  // operation
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [7:0]                     m_axis_tdata,  // successes, zero pad
    output logic      [0:0]                     m_axis_tuser,  // out_of_range
    input  wire logic                           cfg_we,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bts_pkg::FRAC_W-1:0]     cfg_wdata
);

    localparam int DEPTH = MAX_TRIALS * (MAX_TRIALS + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_TRIALS + 1);
    localparam int EW    = bts_pkg::FRAC_W + AW + NW + 2;

    logic [bts_pkg::FRAC_W-1:0] p_fraction_reg;
    logic [bts_pkg::ROWS_W-1:0] rows_loaded_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_fraction_reg  <= 32'h8000_0000;
            rows_loaded_reg <= 7'd64;
        end else if (cfg_we) begin
            case (cfg_index)
                bts_pkg::REG_P_FRACTION:  p_fraction_reg  <= cfg_wdata;
                bts_pkg::REG_ROWS_LOADED: rows_loaded_reg <= cfg_wdata[bts_pkg::ROWS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic          f_push;
    logic [EW-1:0] f_entry;
    logic          q_valid, q_ready;
    logic [EW-1:0] q_entry;
    logic [bts_pkg::SUCC_W-1:0] successes;
    logic          out_of_range;

    bts_front #(
        .MAX_TRIALS (MAX_TRIALS)
    ) u_front (
        .is_sample   (s_axis_tuser[0]),
        .trials      (s_axis_tdata[9:0]),
        .entry_index (s_axis_tdata[15:10]),
        .cdf_value   (s_axis_tdata[47:16]),
        .uniform     (s_axis_tdata[79:48]),
        .rows_loaded (rows_loaded_reg),
        .push        (f_push),
        .entry       (f_entry)
    );

    bts_queue #(
        .WIDTH (EW),
        .DEPTH (bts_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid && f_push),
        .in_ready  (s_axis_tready),
        .in_data   (f_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_entry)
    );

    bts_back #(
        .MAX_TRIALS (MAX_TRIALS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_entry        (q_entry),
        .p_fraction     (p_fraction_reg),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .m_successes    (successes),
        .m_out_of_range (out_of_range)
    );

    assign m_axis_tdata = {1'b0, successes};
    assign m_axis_tuser = out_of_range;

endmodule

`default_nettype wire
